/* rtl/text_mode_console_writer_core_assert.svh */
// Assertion macros shared by the console writer checker.
`ifndef TEXT_MODE_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TMCW_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("tmcw assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define TMCW_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("tmcw assertion failed");

`endif

/* rtl/tmcw_pkg.sv */
// Package with payload types, character codes and controller states.
`timescale 1ns / 1ps

package tmcw_pkg;

  localparam int INDEX_W = 11;
  localparam int CELL_W = 16;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;

  typedef struct packed {
    logic               operation;
    logic [7:0]         char_code;
    logic [7:0]         attribute;
    logic [INDEX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [6:0]        cursor_column;
    logic [4:0]        cursor_line;
    logic [10:0]       cursor_offset;
    logic [CELL_W-1:0] cell_data;
  } result_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_PUT,
    S_COPY,
    S_FILL,
    S_CLEAR,
    S_DONE
  } ctrl_state_t;

endpackage

/* rtl/tmcw_screen_ram.sv */
// Screen cell memory with one write port and one registered read port.
`timescale 1ns / 1ps

module tmcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW = 11
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [tmcw_pkg::CELL_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [tmcw_pkg::CELL_W-1:0] rd_data
);

  logic [tmcw_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tmcw_ctrl.sv */
// Sequencer that owns the cursor and reads, modifies and writes the screen memory.
`timescale 1ns / 1ps

module tmcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int LINES = 25,
  parameter int AW = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  tmcw_pkg::item_t             item,
  input  logic [7:0]                  cfg_attr,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tmcw_pkg::result_t           res,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [tmcw_pkg::CELL_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [tmcw_pkg::CELL_W-1:0] rd_data
);

  localparam int CELLS = COLUMNS * LINES;
  localparam int OW = AW + 1;
  localparam int CLW = $clog2(COLUMNS + 1);
  localparam int LW = $clog2(LINES);
  localparam int IW = (OW > tmcw_pkg::INDEX_W) ? OW : tmcw_pkg::INDEX_W;

  tmcw_pkg::ctrl_state_t state, state_next;

  logic [CLW-1:0]              col, col_next;
  logic [LW-1:0]               line, line_next;
  logic [7:0]                  ch_q, ch_q_next;
  logic [7:0]                  attr_q, attr_q_next;
  logic                        tab_q, tab_q_next;
  logic                        ret_put, ret_put_next;
  logic                        in_range, in_range_next;
  logic [AW-1:0]               cnt, cnt_next;
  logic                        pend, pend_next;
  logic [AW-1:0]               pend_addr, pend_addr_next;
  logic [tmcw_pkg::CELL_W-1:0] data_q, data_q_next;

  logic [OW-1:0]  offset_full;
  logic [IW-1:0]  idx_ext;
  logic [CLW-1:0] col_plus;
  logic           at_wrap;
  logic           at_last_line;
  logic           cnt_last;

  assign offset_full = OW'(line) * OW'(COLUMNS) + OW'(col);
  assign idx_ext = IW'(item.cell_index);
  assign col_plus = col + CLW'(1);
  assign at_wrap = (col == CLW'(COLUMNS));
  assign at_last_line = (line == LW'(LINES - 1));
  assign cnt_last = (cnt == AW'(CELLS - 1));

  assign item_ready = (state == tmcw_pkg::S_IDLE);
  assign res_valid = (state == tmcw_pkg::S_DONE);
  assign res.cursor_column = 7'(col);
  assign res.cursor_line = 5'(line);
  assign res.cursor_offset = 11'(offset_full);
  assign res.cell_data = data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmcw_pkg::S_INIT;
      col <= '0;
      line <= '0;
      cnt <= '0;
      pend <= 1'b0;
      attr_q <= tmcw_pkg::RESET_ATTR;
      tab_q <= 1'b0;
      ret_put <= 1'b0;
    end else begin
      state <= state_next;
      col <= col_next;
      line <= line_next;
      cnt <= cnt_next;
      pend <= pend_next;
      attr_q <= attr_q_next;
      tab_q <= tab_q_next;
      ret_put <= ret_put_next;
    end
  end

  always_ff @(posedge clk) begin
    ch_q <= ch_q_next;
    in_range <= in_range_next;
    pend_addr <= pend_addr_next;
    data_q <= data_q_next;
  end

  always_comb begin
    state_next = state;
    col_next = col;
    line_next = line;
    ch_q_next = ch_q;
    attr_q_next = attr_q;
    tab_q_next = tab_q;
    ret_put_next = ret_put;
    in_range_next = in_range;
    cnt_next = cnt;
    pend_next = 1'b0;
    pend_addr_next = pend_addr;
    data_q_next = data_q;
    wr_en = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    rd_en = 1'b0;
    rd_addr = cnt;

    case (state)
      tmcw_pkg::S_INIT, tmcw_pkg::S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = cnt;
        wr_data = {attr_q, tmcw_pkg::BLANK_CHAR};
        cnt_next = cnt + AW'(1);
        if (cnt_last) begin
          cnt_next = '0;
          state_next = (state == tmcw_pkg::S_INIT) ? tmcw_pkg::S_IDLE : tmcw_pkg::S_DONE;
        end
      end

      tmcw_pkg::S_IDLE: begin
        if (item_valid) begin
          attr_q_next = item.attribute;
          ch_q_next = item.char_code;
          tab_q_next = 1'b0;
          data_q_next = '0;
          if (item.operation == tmcw_pkg::OP_READ) begin
            rd_en = 1'b1;
            rd_addr = idx_ext[AW-1:0];
            in_range_next = (idx_ext < IW'(CELLS));
            state_next = tmcw_pkg::S_READ;
          end else begin
            case (item.char_code)
              tmcw_pkg::CH_NUL, tmcw_pkg::CH_BEL: begin
                state_next = tmcw_pkg::S_DONE;
              end
              tmcw_pkg::CH_FF: begin
                attr_q_next = cfg_attr;
                col_next = '0;
                line_next = '0;
                cnt_next = '0;
                state_next = tmcw_pkg::S_CLEAR;
              end
              tmcw_pkg::CH_CR: begin
                col_next = '0;
                state_next = tmcw_pkg::S_DONE;
              end
              tmcw_pkg::CH_LF: begin
                col_next = '0;
                if (at_last_line) begin
                  ret_put_next = 1'b0;
                  cnt_next = AW'(COLUMNS);
                  state_next = tmcw_pkg::S_COPY;
                end else begin
                  line_next = line + LW'(1);
                  state_next = tmcw_pkg::S_DONE;
                end
              end
              tmcw_pkg::CH_BS: begin
                if (col != '0) begin
                  col_next = col - CLW'(1);
                end
                state_next = tmcw_pkg::S_DONE;
              end
              tmcw_pkg::CH_TAB: begin
                ch_q_next = tmcw_pkg::BLANK_CHAR;
                tab_q_next = 1'b1;
                state_next = tmcw_pkg::S_PUT;
              end
              default: begin
                state_next = tmcw_pkg::S_PUT;
              end
            endcase
          end
        end
      end

      tmcw_pkg::S_READ: begin
        if (in_range) begin
          data_q_next = rd_data;
        end
        state_next = tmcw_pkg::S_DONE;
      end

      tmcw_pkg::S_PUT: begin
        if (at_wrap) begin
          col_next = '0;
          if (at_last_line) begin
            ret_put_next = 1'b1;
            cnt_next = AW'(COLUMNS);
            state_next = tmcw_pkg::S_COPY;
          end else begin
            line_next = line + LW'(1);
          end
        end else begin
          wr_en = 1'b1;
          wr_addr = offset_full[AW-1:0];
          wr_data = {attr_q, ch_q};
          col_next = col_plus;
          if (!(tab_q && (col_plus[2:0] != 3'd0))) begin
            state_next = tmcw_pkg::S_DONE;
          end
        end
      end

      tmcw_pkg::S_COPY: begin
        rd_en = 1'b1;
        rd_addr = cnt;
        wr_en = pend;
        pend_next = 1'b1;
        pend_addr_next = cnt - AW'(COLUMNS);
        cnt_next = cnt + AW'(1);
        if (cnt_last) begin
          cnt_next = AW'(CELLS - COLUMNS);
          state_next = tmcw_pkg::S_FILL;
        end
      end

      tmcw_pkg::S_FILL: begin
        wr_en = 1'b1;
        if (!pend) begin
          wr_addr = cnt;
          wr_data = {attr_q, tmcw_pkg::BLANK_CHAR};
          cnt_next = cnt + AW'(1);
          if (cnt_last) begin
            cnt_next = '0;
            state_next = ret_put ? tmcw_pkg::S_PUT : tmcw_pkg::S_DONE;
          end
        end
      end

      tmcw_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = tmcw_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = tmcw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/text_mode_console_writer_core.sv */
// Top level of the text-mode console writer: configuration, result register and memory.
//
//  channel   signals                              direction
//  cfg       cfg_valid, cfg_ready, cfg_data       write of clear_attribute
//  item      item_valid, item_ready, item         put or read requests
//  result    result_valid, result_ready, result   cursor and read cell
//
// A read passes through S_READ and a plain put through S_PUT before S_DONE offers the result.
// A tab stays in S_PUT and writes spaces up to the next multiple of eight columns, and a wrap
// first moves the cursor to the next line. A scroll copies every line up and blanks the last one,
// and a form feed blanks every cell, both through the single write port of the screen memory.
// After reset the screen memory is cleared before the first transaction is taken;
// configuration writes are always accepted.
// A finished result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps

module text_mode_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int LINES = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                item_valid,
  output logic                item_ready,
  input  tmcw_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output tmcw_pkg::result_t   result
);

  localparam int CELLS = COLUMNS * LINES;
  localparam int AW = $clog2(CELLS);

  logic [7:0]                  clear_attribute;
  logic                        res_valid;
  logic                        res_ready;
  tmcw_pkg::result_t           res;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [tmcw_pkg::CELL_W-1:0] wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [tmcw_pkg::CELL_W-1:0] rd_data;

  assign cfg_ready = 1'b1;
  assign res_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_attribute <= tmcw_pkg::RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      clear_attribute <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      result <= res;
    end
  end

  tmcw_ctrl #(
    .COLUMNS(COLUMNS),
    .LINES(LINES),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .cfg_attr(clear_attribute),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  tmcw_screen_ram #(
    .DEPTH(CELLS),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

/* rtl/tmcw_checker.sv */
// Port-level checker for the console writer and its bind to the top level.
`timescale 1ns / 1ps
`include "text_mode_console_writer_core_assert.svh"

module tmcw_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input tmcw_pkg::result_t result
);

  // The screen clearing pass keeps the item channel closed right after reset.
  `TMCW_ASSERT_NOW(a_busy_after_reset, $past(rst), !item_ready)

  // Items are worked one at a time, so an accepted transaction closes the channel.
  `TMCW_ASSERT_NEXT(a_no_back_to_back, item_valid && item_ready, !item_ready)

  // A new result never rises in the cycle after an item is accepted.
  `TMCW_ASSERT_NOW(a_result_latency, $rose(result_valid), !$past(item_valid && item_ready))

  `TMCW_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
                    result_valid && $stable(result))

endmodule

bind text_mode_console_writer_core tmcw_checker u_tmcw_checker (
  .clk(clk),
  .rst(rst),
  .item_valid(item_valid),
  .item_ready(item_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result(result)
);
